// ===== rtl/cfsrc_pkg.sv =====
// cfsrc_pkg: types and constants shared by the flit injection source
// no dependencies

package cfsrc_pkg;

  localparam int unsigned MAX_FLITS  = 16;
  localparam int unsigned CREDIT_MAX = 255;

  localparam int unsigned DEST_W   = 8;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned MSG_W    = 8;
  localparam int unsigned CREDIT_W = 8;
  localparam int unsigned SRCID_W  = 16;
  localparam int unsigned MAXPKT_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_GENERATE = 2'd0,
    CMD_CREDIT   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_HEAD   = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_TAIL   = 2'd2,
    KIND_SINGLE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_ID   = 2'd0,
    REG_MAX_PACKETS = 2'd1,
    REG_SOURCE_ON   = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [CHAN_W-1:0] chan;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
  } pkt_entry_t;

  typedef struct packed {
    logic capture;
    logic do_generate;
    logic do_credit;
    logic do_tick;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e op;
  } dp_status_t;

  typedef struct packed {
    logic [SRCID_W-1:0]  source_id;
    logic [MAXPKT_W-1:0] max_packets;
    logic                source_on;
  } cfg_t;

endpackage

// ===== rtl/cfsrc_ctrl.sv =====
// cfsrc_ctrl: request sequencer, captures a request in ST_IDLE then executes it in ST_EXEC
// depends on cfsrc_pkg

module cfsrc_ctrl
  import cfsrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      ST_EXEC: begin
        busy_o            = 1'b1;
        cmd_o.load_result = 1'b1;
        cmd_o.do_generate = (status_i.op == CMD_GENERATE);
        cmd_o.do_credit   = (status_i.op == CMD_CREDIT);
        cmd_o.do_tick     = (status_i.op == CMD_TICK);
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  assign done_d = (state_q == ST_EXEC);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

// ===== rtl/cfsrc_dp.sv =====
// cfsrc_dp: packet queue, message tracking, credit counter and result registers
// depends on cfsrc_pkg

module cfsrc_dp
  import cfsrc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  cfg_t                cfg_i,
  input  logic [1:0]          cmd_in_i,
  input  logic [DEST_W-1:0]   dest_i,
  input  logic [LEN_W-1:0]    packet_length_i,
  input  logic [MSG_W-1:0]    message_length_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [CHAN_W-1:0]   credit_channel_i,
  input  logic [4:0]          credit_amount_i,
  output logic                flit_valid_o,
  output logic [1:0]          flit_kind_o,
  output logic [DEST_W-1:0]   flit_dest_o,
  output logic [CHAN_W-1:0]   flit_channel_o,
  output logic [31:0]         flit_packet_id_o,
  output logic [POS_W-1:0]    flit_position_o,
  output logic [LEN_W-1:0]    flit_total_o,
  output logic                packet_accepted_o,
  output logic [4:0]          queued_count_o,
  output logic [CREDIT_W-1:0] credit_level_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > MAXPKT_W) ? CW : MAXPKT_W;

  // captured request
  cmd_e                op_q;
  logic [DEST_W-1:0]   dest_q;
  logic [LEN_W-1:0]    plen_q;
  logic [MSG_W-1:0]    mlen_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [CHAN_W-1:0]   cchan_q;
  logic [4:0]          camt_q;

  // queue and source state
  pkt_entry_t          store_mem [QUEUE_DEPTH];
  pkt_entry_t          rd_data_q;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [POS_W-1:0]    head_pos_q, head_pos_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic [IDX_W-1:0]    pkt_idx_q, pkt_idx_d;
  logic [MSG_W-1:0]    msg_pos_q, msg_pos_d;
  logic [MSG_W-1:0]    msg_size_q, msg_size_d;
  logic [DEST_W-1:0]   cur_dest_q, cur_dest_d;
  logic [LEN_W-1:0]    cur_len_q, cur_len_d;

  logic                full;
  logic                gen_ok;
  logic                boundary;
  logic [LEN_W-1:0]    plen_clamped;
  pkt_entry_t          wr_entry;
  logic [CREDIT_W:0]   credit_sum;
  logic                tick_ok;
  logic [LEN_W-1:0]    pos_next;
  logic                pkt_end;
  kind_e               kind;

  assign status_o.op = op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= cmd_e'(cmd_in_i);
      dest_q  <= dest_i;
      plen_q  <= packet_length_i;
      mlen_q  <= message_length_i;
      chan_q  <= channel_i;
      cchan_q <= credit_channel_i;
      camt_q  <= credit_amount_i;
    end
  end

  // generate path
  assign full = (LW'(cnt_q) >= LW'(cfg_i.max_packets)) || (cnt_q == CW'(QUEUE_DEPTH));
  assign gen_ok   = cmd_i.do_generate && cfg_i.source_on && !full;
  assign boundary = (msg_pos_q == msg_size_q);

  always_comb begin
    if (plen_q == '0) begin
      plen_clamped = LEN_W'(1);
    end else if (plen_q > LEN_W'(MAX_FLITS)) begin
      plen_clamped = LEN_W'(MAX_FLITS);
    end else begin
      plen_clamped = plen_q;
    end
  end

  always_comb begin
    cur_dest_d = cur_dest_q;
    cur_len_d  = cur_len_q;
    msg_size_d = msg_size_q;
    msg_pos_d  = msg_pos_q;
    pkt_idx_d  = pkt_idx_q;
    wr_ptr_d   = wr_ptr_q;
    if (gen_ok) begin
      if (boundary) begin
        cur_dest_d = dest_q;
        cur_len_d  = plen_clamped;
        msg_size_d = (mlen_q == '0) ? MSG_W'(1) : mlen_q;
        msg_pos_d  = MSG_W'(1);
      end else begin
        msg_pos_d = msg_pos_q + MSG_W'(1);
      end
      pkt_idx_d = pkt_idx_q + IDX_W'(1);
      wr_ptr_d  = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
  end

  assign wr_entry.dest = cur_dest_d;
  assign wr_entry.chan = chan_q;
  assign wr_entry.len  = cur_len_d;
  assign wr_entry.idx  = pkt_idx_d;

  always_ff @(posedge clk_i) begin
    if (gen_ok) begin
      store_mem[wr_ptr_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= store_mem[rd_ptr_q];
  end

  // send path
  assign tick_ok  = cmd_i.do_tick && cfg_i.source_on && (cnt_q != '0) && (credit_q != '0);
  assign pos_next = LEN_W'(head_pos_q) + LEN_W'(1);
  assign pkt_end  = (pos_next >= rd_data_q.len);

  always_comb begin
    if (rd_data_q.len <= LEN_W'(1)) begin
      kind = KIND_SINGLE;
    end else if (head_pos_q == '0) begin
      kind = KIND_HEAD;
    end else if (pkt_end) begin
      kind = KIND_TAIL;
    end else begin
      kind = KIND_BODY;
    end
  end

  assign credit_sum = {1'b0, credit_q} + (CREDIT_W + 1)'(camt_q);

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    head_pos_d = head_pos_q;
    credit_d   = credit_q;
    cnt_d      = cnt_q;
    if (gen_ok) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.do_credit && (cchan_q == '0)) begin
      credit_d = (credit_sum > (CREDIT_W + 1)'(CREDIT_MAX)) ? CREDIT_W'(CREDIT_MAX)
                                                             : credit_sum[CREDIT_W-1:0];
    end
    if (tick_ok) begin
      credit_d = credit_q - CREDIT_W'(1);
      if (pkt_end) begin
        head_pos_d = '0;
        rd_ptr_d   = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
        cnt_d      = cnt_q - CW'(1);
      end else begin
        head_pos_d = pos_next[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cnt_q      <= '0;
      head_pos_q <= '0;
      credit_q   <= '0;
      pkt_idx_q  <= '0;
      msg_pos_q  <= '0;
      msg_size_q <= '0;
      cur_dest_q <= '0;
      cur_len_q  <= LEN_W'(1);
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      cnt_q      <= cnt_d;
      head_pos_q <= head_pos_d;
      credit_q   <= credit_d;
      pkt_idx_q  <= pkt_idx_d;
      msg_pos_q  <= msg_pos_d;
      msg_size_q <= msg_size_d;
      cur_dest_q <= cur_dest_d;
      cur_len_q  <= cur_len_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      flit_valid_o      <= tick_ok;
      flit_kind_o       <= tick_ok ? kind : KIND_HEAD;
      flit_dest_o       <= tick_ok ? rd_data_q.dest : '0;
      flit_channel_o    <= tick_ok ? rd_data_q.chan : '0;
      flit_packet_id_o  <= tick_ok ? {cfg_i.source_id, rd_data_q.idx} : '0;
      flit_position_o   <= tick_ok ? head_pos_q : '0;
      flit_total_o      <= tick_ok ? rd_data_q.len : '0;
      packet_accepted_o <= gen_ok;
      queued_count_o    <= 5'(cnt_d);
      credit_level_o    <= credit_d;
    end
  end

endmodule

// ===== rtl/credit_flit_injection_source_unit.sv =====
// credit_flit_injection_source_unit: top level of the flit injection source
// depends on cfsrc_pkg, cfsrc_ctrl, cfsrc_dp
//
// Usage: a request (generate, credit return or send tick, chosen by cmd_i)
// is taken at a rising edge with start_i high and busy_o low. Each request
// gives exactly one result on the flit_*, packet_accepted_o, queued_count_o
// and credit_level_o ports, marked by done_o for one cycle; the receiver
// cannot hold it off and must take it in that cycle.
// Timing: the request is captured in the accept cycle while the head entry
// of the packet queue is read from its registered-read memory; the next
// cycle (busy_o high) executes and loads the result registers; done_o rises
// the cycle after that. No new request is taken while busy_o is high; done_o
// of one request overlaps the accept of the next.
// Configuration: cfg_we_i writes register cfg_idx_i (0 source id, 1 max
// packets, 2 source on) at once; writes are to be made only while idle, but
// the block does not enforce this.
// Reset: queue empty, credits zero, source on, limit 16, source id zero.

module credit_flit_injection_source_unit
  import cfsrc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  done_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            cmd_i,
  input  logic [DEST_W-1:0]     dest_i,
  input  logic [LEN_W-1:0]      packet_length_i,
  input  logic [MSG_W-1:0]      message_length_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [CHAN_W-1:0]     credit_channel_i,
  input  logic [4:0]            credit_amount_i,
  output logic                  flit_valid_o,
  output logic [1:0]            flit_kind_o,
  output logic [DEST_W-1:0]     flit_dest_o,
  output logic [CHAN_W-1:0]     flit_channel_o,
  output logic [31:0]           flit_packet_id_o,
  output logic [POS_W-1:0]      flit_position_o,
  output logic [LEN_W-1:0]      flit_total_o,
  output logic                  packet_accepted_o,
  output logic [4:0]            queued_count_o,
  output logic [CREDIT_W-1:0]   credit_level_o
);

  cfg_t       cfg_q;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_id   <= '0;
      cfg_q.max_packets <= MAXPKT_W'(16);
      cfg_q.source_on   <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SOURCE_ID:   cfg_q.source_id   <= cfg_data_i[SRCID_W-1:0];
        REG_MAX_PACKETS: cfg_q.max_packets <= cfg_data_i[MAXPKT_W-1:0];
        REG_SOURCE_ON:   cfg_q.source_on   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  cfsrc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (ctrl_cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  cfsrc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctrl_cmd),
    .status_o          (dp_status),
    .cfg_i             (cfg_q),
    .cmd_in_i          (cmd_i),
    .dest_i            (dest_i),
    .packet_length_i   (packet_length_i),
    .message_length_i  (message_length_i),
    .channel_i         (channel_i),
    .credit_channel_i  (credit_channel_i),
    .credit_amount_i   (credit_amount_i),
    .flit_valid_o      (flit_valid_o),
    .flit_kind_o       (flit_kind_o),
    .flit_dest_o       (flit_dest_o),
    .flit_channel_o    (flit_channel_o),
    .flit_packet_id_o  (flit_packet_id_o),
    .flit_position_o   (flit_position_o),
    .flit_total_o      (flit_total_o),
    .packet_accepted_o (packet_accepted_o),
    .queued_count_o    (queued_count_o),
    .credit_level_o    (credit_level_o)
  );

  a_accept_execs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not enter execute");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (!busy_o && done_o))
    else $error("execute did not finish with a result strobe");

  a_flit_costs_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && flit_valid_o) |-> (credit_level_o != CREDIT_W'(CREDIT_MAX)))
    else $error("flit sent with credit level at maximum");

  a_accept_no_flit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && packet_accepted_o) |-> (!flit_valid_o && queued_count_o != '0))
    else $error("accepted packet result inconsistent");

endmodule

// ===== verif/cfsrc_checker.sv =====
// cfsrc_checker: predicts the flit injection source request by request and compares every result
// depends on cfsrc_pkg; watches the request, config and result ports of the unit

module cfsrc_checker
  import cfsrc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_o,
  input  logic                  done_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            cmd_i,
  input  logic [DEST_W-1:0]     dest_i,
  input  logic [LEN_W-1:0]      packet_length_i,
  input  logic [MSG_W-1:0]      message_length_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [CHAN_W-1:0]     credit_channel_i,
  input  logic [4:0]            credit_amount_i,
  input  logic                  flit_valid_o,
  input  logic [1:0]            flit_kind_o,
  input  logic [DEST_W-1:0]     flit_dest_o,
  input  logic [CHAN_W-1:0]     flit_channel_o,
  input  logic [31:0]           flit_packet_id_o,
  input  logic [POS_W-1:0]      flit_position_o,
  input  logic [LEN_W-1:0]      flit_total_o,
  input  logic                  packet_accepted_o,
  input  logic [4:0]            queued_count_o,
  input  logic [CREDIT_W-1:0]   credit_level_o,
  output int                    mismatches,
  output int                    outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [DEST_W-1:0]   dest;
    logic [CHAN_W-1:0]   chan;
    logic [31:0]         packet_id;
    logic [POS_W-1:0]    position;
    logic [LEN_W-1:0]    total;
    logic                accepted;
    logic [4:0]          queued;
    logic [CREDIT_W-1:0] credits;
  } flit_result_t;

  flit_result_t expected_flits[$];

  logic [SRCID_W-1:0]  src_id;
  logic [MAXPKT_W-1:0] max_pkts;
  logic                src_on;

  pkt_entry_t          pkt_queue[QDEPTH];
  logic [3:0]          rd_ptr, wr_ptr;
  logic [4:0]          pkt_cnt;
  logic [POS_W-1:0]    head_pos;
  logic [CREDIT_W-1:0] credits;
  logic [IDX_W-1:0]    pkt_idx;
  logic [MSG_W-1:0]    msg_pos, msg_size;
  logic [DEST_W-1:0]   cur_dest;
  logic [LEN_W-1:0]    cur_len;

  flit_result_t        res, want;
  pkt_entry_t          head;
  int                  limit, sum, plen;

  assign outstanding = expected_flits.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, exp);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_flits.delete();
      mismatches = 0;
      src_id   = '0;
      max_pkts = 5'd16;
      src_on   = 1'b1;
      rd_ptr   = '0;
      wr_ptr   = '0;
      pkt_cnt  = '0;
      head_pos = '0;
      credits  = '0;
      pkt_idx  = '0;
      msg_pos  = '0;
      msg_size = '0;
      cur_dest = '0;
      cur_len  = 5'd1;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_SOURCE_ID:   src_id = cfg_data_i[SRCID_W-1:0];
          REG_MAX_PACKETS: max_pkts = cfg_data_i[MAXPKT_W-1:0];
          REG_SOURCE_ON:   src_on = cfg_data_i[0];
          default: ;
        endcase
      end

      if (done_o) begin
        if (expected_flits.size() == 0) begin
          report("result with no request pending", 32'(flit_valid_o), 32'd0);
        end else begin
          want = expected_flits.pop_front();
          if (flit_valid_o !== want.valid)
            report("flit_valid", 32'(flit_valid_o), 32'(want.valid));
          if (flit_kind_o !== want.kind)
            report("flit_kind", 32'(flit_kind_o), 32'(want.kind));
          if (flit_dest_o !== want.dest)
            report("flit_dest", 32'(flit_dest_o), 32'(want.dest));
          if (flit_channel_o !== want.chan)
            report("flit_channel", 32'(flit_channel_o), 32'(want.chan));
          if (flit_packet_id_o !== want.packet_id)
            report("flit_packet_id", flit_packet_id_o, want.packet_id);
          if (flit_position_o !== want.position)
            report("flit_position", 32'(flit_position_o), 32'(want.position));
          if (flit_total_o !== want.total)
            report("flit_total", 32'(flit_total_o), 32'(want.total));
          if (packet_accepted_o !== want.accepted)
            report("packet_accepted", 32'(packet_accepted_o), 32'(want.accepted));
          if (queued_count_o !== want.queued)
            report("queued_count", 32'(queued_count_o), 32'(want.queued));
          if (credit_level_o !== want.credits)
            report("credit_level", 32'(credit_level_o), 32'(want.credits));
        end
      end

      if (start_i && !busy_o) begin
        res = '0;
        case (cmd_e'(cmd_i))
          CMD_GENERATE: begin
            limit = (max_pkts > QDEPTH) ? QDEPTH : int'(max_pkts);
            if (src_on && int'(pkt_cnt) < limit) begin
              // new message: latch destination and sizes
              if (msg_pos == msg_size) begin
                msg_size = (message_length_i == 0) ? 8'd1 : message_length_i;
                msg_pos  = '0;
                cur_dest = dest_i;
                plen = int'(packet_length_i);
                if (plen == 0) plen = 1;
                if (plen > MAX_FLITS) plen = MAX_FLITS;
                cur_len = LEN_W'(plen);
              end
              pkt_idx = pkt_idx + IDX_W'(1);
              msg_pos = msg_pos + MSG_W'(1);
              pkt_queue[wr_ptr] = '{dest: cur_dest, chan: channel_i, len: cur_len, idx: pkt_idx};
              wr_ptr  = wr_ptr + 4'd1;
              pkt_cnt = pkt_cnt + 5'd1;
              res.accepted = 1'b1;
            end
          end
          CMD_CREDIT: begin
            if (credit_channel_i == 0) begin
              sum = int'(credits) + int'(credit_amount_i);
              credits = (sum > CREDIT_MAX) ? CREDIT_W'(CREDIT_MAX) : CREDIT_W'(sum);
            end
          end
          CMD_TICK: begin
            if (src_on && pkt_cnt != 0 && credits != 0) begin
              head = pkt_queue[rd_ptr];
              res.valid = 1'b1;
              if (head.len <= 1)
                res.kind = KIND_SINGLE;
              else if (head_pos == 0)
                res.kind = KIND_HEAD;
              else if (int'(head_pos) + 1 >= int'(head.len))
                res.kind = KIND_TAIL;
              else
                res.kind = KIND_BODY;
              res.dest      = head.dest;
              res.chan      = head.chan;
              res.packet_id = {src_id, head.idx};
              res.position  = head_pos;
              res.total     = head.len;
              credits = credits - CREDIT_W'(1);
              if (int'(head_pos) + 1 >= int'(head.len)) begin
                head_pos = '0;
                rd_ptr   = rd_ptr + 4'd1;
                pkt_cnt  = pkt_cnt - 5'd1;
              end else begin
                head_pos = head_pos + POS_W'(1);
              end
            end
          end
          default: ;
        endcase
        res.queued  = pkt_cnt;
        res.credits = credits;
        expected_flits.push_back(res);
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// tb: drives directed and random requests and config phases into the flit injection source
// depends on cfsrc_pkg, credit_flit_injection_source_unit and cfsrc_checker

module tb;

  import cfsrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_REQS  = 166;

  typedef struct packed {
    cmd_e              cmd;
    logic [DEST_W-1:0] dest;
    logic [LEN_W-1:0]  plen;
    logic [MSG_W-1:0]  mlen;
    logic [CHAN_W-1:0] chan;
    logic [CHAN_W-1:0] cchan;
    logic [4:0]        camt;
  } request_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  done_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic [1:0]            cmd_i;
  logic [DEST_W-1:0]     dest_i;
  logic [LEN_W-1:0]      packet_length_i;
  logic [MSG_W-1:0]      message_length_i;
  logic [CHAN_W-1:0]     channel_i;
  logic [CHAN_W-1:0]     credit_channel_i;
  logic [4:0]            credit_amount_i;
  logic                  flit_valid_o;
  logic [1:0]            flit_kind_o;
  logic [DEST_W-1:0]     flit_dest_o;
  logic [CHAN_W-1:0]     flit_channel_o;
  logic [31:0]           flit_packet_id_o;
  logic [POS_W-1:0]      flit_position_o;
  logic [LEN_W-1:0]      flit_total_o;
  logic                  packet_accepted_o;
  logic [4:0]            queued_count_o;
  logic [CREDIT_W-1:0]   credit_level_o;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_cnt;

  credit_flit_injection_source_unit dut (.*);

  cfsrc_checker u_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("credit_flit_injection_source_unit: mismatch");
    $finish;
  end

  function automatic request_t mk(input cmd_e cmd, input logic [7:0] dest,
                                  input logic [4:0] plen, input logic [7:0] mlen,
                                  input logic [1:0] chan, input logic [1:0] cchan,
                                  input logic [4:0] camt);
    request_t r;
    r = '{cmd: cmd, dest: dest, plen: plen, mlen: mlen, chan: chan, cchan: cchan, camt: camt};
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.cmd  = (pick < 30) ? CMD_GENERATE : (pick < 50) ? CMD_CREDIT :
             (pick < 95) ? CMD_TICK : CMD_NONE;
    r.dest = DEST_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    r.plen = (pick < 80) ? LEN_W'($urandom_range(1, 4)) :
             (pick < 95) ? LEN_W'($urandom_range(0, 31)) : 5'd16;
    r.mlen = ($urandom_range(0, 99) < 75) ? MSG_W'($urandom_range(0, 4))
                                          : MSG_W'($urandom_range(0, 255));
    r.chan = CHAN_W'($urandom_range(0, 3));
    r.cchan = ($urandom_range(0, 99) < 70) ? 2'd0 : CHAN_W'($urandom_range(0, 3));
    r.camt = 5'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic send_request(input request_t r);
    start_i          <= 1'b1;
    cmd_i            <= r.cmd;
    dest_i           <= r.dest;
    packet_length_i  <= r.plen;
    message_length_i <= r.mlen;
    channel_i        <= r.chan;
    credit_channel_i <= r.cchan;
    credit_amount_i  <= r.camt;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [15:0] id, input logic [4:0] limit,
                                input logic enable);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SOURCE_ID;
    cfg_data_i <= id;
    @(negedge clk_i);
    cfg_idx_i  <= REG_MAX_PACKETS;
    cfg_data_i <= 16'(limit);
    @(negedge clk_i);
    cfg_idx_i  <= REG_SOURCE_ON;
    cfg_data_i <= 16'(enable);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [15:0] id;
    logic [4:0]  limit;
    logic        enable;
    int          idle_pct;

    rst_ni           = 1'b0;
    start_i          = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    cmd_i            = '0;
    dest_i           = '0;
    packet_length_i  = '0;
    message_length_i = '0;
    channel_i        = '0;
    credit_channel_i = '0;
    credit_amount_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_settings(16'hFFFF, 5'd16, 1'b1);

    send_request(mk(CMD_TICK,     8'h00, 5'd0,  8'd0,   2'd0, 2'd0, 5'd0));
    send_request(mk(CMD_CREDIT,   8'h00, 5'd0,  8'd0,   2'd0, 2'd0, 5'd0));
    send_request(mk(CMD_CREDIT,   8'h00, 5'd0,  8'd0,   2'd0, 2'd3, 5'd31));
    send_request(mk(CMD_GENERATE, 8'hFF, 5'd0,  8'd0,   2'd3, 2'd0, 5'd0));
    send_request(mk(CMD_TICK,     8'h00, 5'd0,  8'd0,   2'd0, 2'd0, 5'd0));
    send_request(mk(CMD_CREDIT,   8'h00, 5'd0,  8'd0,   2'd0, 2'd0, 5'd31));
    send_request(mk(CMD_TICK,     8'h00, 5'd0,  8'd0,   2'd0, 2'd0, 5'd0));
    send_request(mk(CMD_GENERATE, 8'h00, 5'd31, 8'd2,   2'd0, 2'd0, 5'd0));
    send_request(mk(CMD_GENERATE, 8'h55, 5'd3,  8'd9,   2'd2, 2'd0, 5'd0));
    send_request(mk(CMD_GENERATE, 8'hAA, 5'd2,  8'd255, 2'd1, 2'd0, 5'd0));
    send_request(mk(CMD_GENERATE, 8'h7F, 5'd16, 8'd1,   2'd1, 2'd0, 5'd0));
    repeat (3) send_request(mk(CMD_TICK, 8'h00, 5'd0, 8'd0, 2'd0, 2'd0, 5'd0));
    send_request(mk(CMD_NONE,     8'hFF, 5'd31, 8'd255, 2'd3, 2'd3, 5'd31));
    repeat (8) send_request(mk(CMD_CREDIT, 8'h00, 5'd0, 8'd0, 2'd0, 2'd0, 5'd31));
    send_request(mk(CMD_CREDIT,   8'h00, 5'd0,  8'd0,   2'd0, 2'd1, 5'd16));
    send_request(mk(CMD_CREDIT,   8'h00, 5'd0,  8'd0,   2'd0, 2'd0, 5'd16));

    for (int phase = 0; phase < 8; phase++) begin
      settle();
      id = 16'($urandom_range(0, 65535));
      case (phase)
        0: begin limit = 5'd16; enable = 1'b1; end
        1: begin id = 16'h0000; limit = 5'd1; enable = 1'b1; end
        2: begin id = 16'hFFFF; limit = 5'd0; enable = 1'b1; end
        3: begin limit = 5'd31; enable = 1'b1; end
        4: begin limit = 5'd16; enable = 1'b0; end
        5: begin limit = 5'd8; enable = 1'b1; end
        6: begin limit = 5'd2; enable = 1'b1; end
        default: begin limit = 5'd16; enable = 1'b1; end
      endcase
      idle_pct = (phase < 3) ? 21 : (phase < 6) ? 58 : 0;
      write_settings(id, limit, enable);
      if (phase == 0) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= REG_UNUSED;
        cfg_data_i <= CFG_DATA_W'($urandom_range(0, 65535));
        @(negedge clk_i);
        cfg_we_i   <= 1'b0;
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) settle();
        while ($urandom_range(0, 99) < idle_pct) begin
          start_i <= 1'b0;
          @(negedge clk_i);
        end
        send_request(random_request());
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0)
      $display("credit_flit_injection_source_unit: match");
    else
      $display("credit_flit_injection_source_unit: mismatch");
    $finish;
  end

endmodule
